// ===== sv/ple_pkg.sv =====
// Shared types, constants and operation codes of the positional list engine.
package ple_pkg;

  // List geometry.
  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int LEN_W      = $clog2(DEPTH + 1);
  localparam int POS_W      = 8;
  localparam int CAP_W      = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  // Operation codes.
  localparam logic [1:0] FN_INSERT = 2'd0;
  localparam logic [1:0] FN_REMOVE = 2'd1;
  localparam logic [1:0] FN_FIND   = 2'd2;
  localparam logic [1:0] FN_SET    = 2'd3;

  // Status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_BAD_POS   = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  // Input word.
  typedef struct packed {
    logic [1:0]                   func;
    logic [POS_W-1:0]             position;
    logic signed [DATA_WIDTH-1:0] value;
  } in_word_t;

  // Result word.
  typedef struct packed {
    logic [1:0]                   status;
    logic signed [DATA_WIDTH-1:0] value_out;
    logic [LEN_W-1:0]             found_position;
    logic [LEN_W-1:0]             count;
  } out_word_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic                         shift_up;
    logic                         shift_down;
    logic                         load;
    logic [IDX_W-1:0]             idx;
    logic [LEN_W-1:0]             len;
    logic signed [DATA_WIDTH-1:0] value;
  } cell_cmd_t;

endpackage

// ===== sv/positional_list_engine_unit.sv =====
// Top level of the positional list engine: command decode, cell chain and result stage.
//
//  channel | direction | handshake          | word
//  in_     | input     | in_valid/in_stall   | ple_pkg::in_word_t
//  out_    | output    | out_valid/out_stall | ple_pkg::out_word_t
//  cfg_    | input     | cfg_valid/cfg_ready | capacity, 5 bits
//
// One word is accepted per cycle unless in_stall; results pass match then output stage.
// The cells update at the edge that accepts a word, so the next word sees the new list.
// The find match vector is registered and priority encoded in the result stage.
// Reset empties the list and sets the capacity to 16; cfg_ready is always high.
// A stall on the output holds the result stage and then the match stage behind it.
module positional_list_engine_unit (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  ple_pkg::in_word_t     in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output ple_pkg::out_word_t    out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [ple_pkg::CAP_W-1:0] cfg_data
);
  import ple_pkg::*;

  logic [CAP_W-1:0]  cap_r;
  logic [LEN_W-1:0]  len_r;
  logic [LEN_W-1:0]  len_nxt;
  logic [LEN_W-1:0]  eff_cap;
  logic              in_acc;
  logic              pend_adv;
  logic              ins_ok;
  logic              rs_ok;
  logic              pos_ok_ins;
  logic              pos_ok_rs;
  logic [IDX_W-1:0]  idx;
  logic [1:0]        status_a;
  logic signed [DATA_WIDTH-1:0] removed;
  cell_cmd_t         cmd;

  logic signed [DATA_WIDTH-1:0] cell_data [DEPTH];
  logic [DEPTH-1:0]  match_vec;

  logic              pend_valid_r;
  logic              pend_find_r;
  logic [1:0]        pend_status_r;
  logic signed [DATA_WIDTH-1:0] pend_value_r;
  logic [LEN_W-1:0]  pend_count_r;
  logic [DEPTH-1:0]  pend_match_r;

  logic              out_valid_r;
  out_word_t         out_word_r;
  out_word_t         result;
  logic              hit;
  logic [LEN_W-1:0]  fpos;

  // Handshakes.
  assign cfg_ready = 1'b1;
  assign pend_adv  = !out_valid_r || !out_stall;
  assign in_stall  = pend_valid_r && !pend_adv;
  assign in_acc    = in_valid && !in_stall;

  // Range and capacity checks against the current length.
  assign eff_cap    = (cap_r > CAP_W'(DEPTH)) ? LEN_W'(DEPTH) : LEN_W'(cap_r);
  assign pos_ok_ins = (in_data.position != '0) &&
                      ({1'b0, in_data.position} <= ((POS_W + 1)'(len_r) + (POS_W + 1)'(1)));
  assign pos_ok_rs  = (in_data.position != '0) && (in_data.position <= POS_W'(len_r));
  assign idx        = IDX_W'(in_data.position - POS_W'(1));
  assign removed    = cell_data[idx];

  // Decode the word into a cell command, a status and the new length.
  always_comb begin
    ins_ok    = 1'b0;
    rs_ok     = 1'b0;
    status_a  = ST_OK;
    len_nxt   = len_r;
    cmd.shift_up   = 1'b0;
    cmd.shift_down = 1'b0;
    cmd.load       = 1'b0;
    cmd.idx        = idx;
    cmd.len        = len_r;
    cmd.value      = in_data.value;
    unique case (in_data.func)
      FN_INSERT: begin
        if (len_r >= eff_cap) begin
          status_a = ST_FULL;
        end else if (!pos_ok_ins) begin
          status_a = ST_BAD_POS;
        end else begin
          ins_ok = 1'b1;
        end
        cmd.shift_up = in_acc && ins_ok;
        cmd.load     = in_acc && ins_ok;
        if (ins_ok) begin
          len_nxt = len_r + LEN_W'(1);
        end
      end
      FN_REMOVE: begin
        rs_ok    = pos_ok_rs;
        status_a = pos_ok_rs ? ST_OK : ST_BAD_POS;
        cmd.shift_down = in_acc && rs_ok;
        if (rs_ok) begin
          len_nxt = len_r - LEN_W'(1);
        end
      end
      FN_FIND: begin
        status_a = ST_OK;
      end
      FN_SET: begin
        rs_ok    = pos_ok_rs;
        status_a = pos_ok_rs ? ST_OK : ST_BAD_POS;
        cmd.load = in_acc && rs_ok;
      end
    endcase
  end

  // The chain of cells, each wired to its neighbors; the end cells see zero past the chain.
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic signed [DATA_WIDTH-1:0] left_d;
    logic signed [DATA_WIDTH-1:0] right_d;
    if (k == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_mid_l
      assign left_d = cell_data[k-1];
    end
    if (k == DEPTH - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_mid_r
      assign right_d = cell_data[k+1];
    end
    ple_cell u_cell (
      .clk        (clk),
      .my_idx     (IDX_W'(k)),
      .cmd        (cmd),
      .left_data  (left_d),
      .right_data (right_d),
      .data_out   (cell_data[k]),
      .match      (match_vec[k])
    );
  end

  // Length and capacity registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
      cap_r <= CAP_RESET;
    end else begin
      if (in_acc) begin
        len_r <= len_nxt;
      end
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_data;
      end
    end
  end

  // Match stage: holds status, removed value, count and the find match vector.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
    end else if (pend_adv || !pend_valid_r) begin
      pend_valid_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      pend_find_r   <= (in_data.func == FN_FIND);
      pend_status_r <= status_a;
      pend_value_r  <= (in_data.func == FN_REMOVE && rs_ok) ? removed : '0;
      pend_count_r  <= len_nxt;
      pend_match_r  <= match_vec;
    end
  end

  // First matching slot wins.
  always_comb begin
    hit  = 1'b0;
    fpos = '0;
    for (int k = DEPTH - 1; k >= 0; k--) begin
      if (pend_match_r[k]) begin
        hit  = 1'b1;
        fpos = LEN_W'(k + 1);
      end
    end
  end

  always_comb begin
    result.value_out      = pend_value_r;
    result.count          = pend_count_r;
    result.status         = pend_status_r;
    result.found_position = '0;
    if (pend_find_r) begin
      result.status         = hit ? ST_OK : ST_NOT_FOUND;
      result.found_position = fpos;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pend_adv) begin
      out_valid_r <= pend_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_adv && pend_valid_r) begin
      out_word_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

  // The length never passes the list depth.
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LEN_W'(DEPTH))
    else $error("list length exceeds depth");

  // A successful insert grows the list by exactly one entry.
  a_ins_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_data.func == FN_INSERT && ins_ok) |=> (len_r == $past(len_r) + LEN_W'(1)))
    else $error("insert did not grow the list");

  // A word in the match stage is never dropped while the output is stalled.
  a_pend_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_valid_r && !pend_adv) |=> pend_valid_r)
    else $error("pending word lost");

  // A failed find reports position zero.
  a_nf_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_word_r.status == ST_NOT_FOUND) |-> (out_word_r.found_position == '0))
    else $error("not found with nonzero position");

endmodule

// ===== sv/ple_cell.sv =====
// One list slot: holds an entry, shifts with its neighbors and compares for find.
module ple_cell (
  input  logic                                 clk,
  input  logic [ple_pkg::IDX_W-1:0]            my_idx,
  input  ple_pkg::cell_cmd_t                   cmd,
  input  logic signed [ple_pkg::DATA_WIDTH-1:0] left_data,
  input  logic signed [ple_pkg::DATA_WIDTH-1:0] right_data,
  output logic signed [ple_pkg::DATA_WIDTH-1:0] data_out,
  output logic                                 match
);
  import ple_pkg::*;

  logic signed [DATA_WIDTH-1:0] entry_r;
  logic signed [DATA_WIDTH-1:0] entry_nxt;

  // Pick the next entry: neighbor on a shift, the broadcast value on a load.
  always_comb begin
    entry_nxt = entry_r;
    if (cmd.shift_up && (my_idx > cmd.idx)) begin
      entry_nxt = left_data;
    end else if (cmd.shift_down && (my_idx >= cmd.idx)) begin
      entry_nxt = right_data;
    end else if (cmd.load && (my_idx == cmd.idx)) begin
      entry_nxt = cmd.value;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  // Only slots inside the current length take part in a find.
  assign match    = (entry_r == cmd.value) && (LEN_W'(my_idx) < cmd.len);
  assign data_out = entry_r;

endmodule

// ===== tb/sv/tb_positional_list_engine_unit.sv =====
`timescale 1ns / 1ps
// Testbench for the positional list engine: directed and random list operations checked per field.
module tb_positional_list_engine_unit;
  import ple_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 80;
  localparam int RANDOM_ITEMS = 150;

  localparam logic [DATA_WIDTH-1:0] VAL_MAX = 32'h7fff_ffff;
  localparam logic [DATA_WIDTH-1:0] VAL_MIN = 32'h8000_0000;
  localparam logic [DATA_WIDTH-1:0] VAL_NEG = 32'hffff_ffff;

  // Contents, length and capacity of the list as the block should hold them.
  typedef struct packed {
    logic [DEPTH-1:0][DATA_WIDTH-1:0] slot;
    logic [LEN_W-1:0]                 len;
    logic [CAP_W-1:0]                 cap;
  } list_image_t;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  in_word_t           in_data   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  out_word_t          out_data;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CAP_W-1:0]   cfg_data  = '0;

  in_word_t    words_to_send [$];
  out_word_t   results_due [$];
  list_image_t list_model;
  list_image_t list_after;
  list_image_t plan_image;
  out_word_t   oldest_result;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int fail_count    = 0;
  int result_index  = 0;
  int cycle_count   = 0;
  int hold_left     = 0;
  logic hold_request = 1'b0;
  logic hold_spent   = 1'b0;

  // Values that recur often, so that finds hit duplicates and the extremes.
  logic [DATA_WIDTH-1:0] value_pool [8] = '{32'd0, VAL_NEG, VAL_MIN, VAL_MAX, 32'd1,
                                            32'h5555_5555, 32'haaaa_aaaa, 32'd42};

  positional_list_engine_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // Clock with a 4 ns period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Applies one operation to a list image and gives the result word it should produce.
  function automatic out_word_t apply_list_op(input list_image_t cur, input in_word_t w,
                                              output list_image_t nxt);
    out_word_t r;
    int eff_cap;
    int pos;
    int len;
    int k;
    r       = '0;
    nxt     = cur;
    eff_cap = (int'(cur.cap) > DEPTH) ? DEPTH : int'(cur.cap);
    pos     = int'(w.position);
    len     = int'(cur.len);
    case (w.func)
      FN_INSERT: begin
        // The full check wins over the position check.
        if (len >= eff_cap) begin
          r.status = ST_FULL;
        end else if (pos < 1 || pos > len + 1) begin
          r.status = ST_BAD_POS;
        end else begin
          for (k = len; k >= pos; k--) nxt.slot[k] = nxt.slot[k-1];
          nxt.slot[pos-1] = w.value;
          nxt.len = cur.len + 1'b1;
        end
      end
      FN_REMOVE: begin
        if (pos < 1 || pos > len) begin
          r.status = ST_BAD_POS;
        end else begin
          r.value_out = cur.slot[pos-1];
          for (k = pos - 1; k + 1 < len; k++) nxt.slot[k] = nxt.slot[k+1];
          nxt.len = cur.len - 1'b1;
        end
      end
      FN_FIND: begin
        // First match wins; the position field plays no part.
        r.status = ST_NOT_FOUND;
        for (k = 0; k < len; k++) begin
          if (r.status == ST_NOT_FOUND && cur.slot[k] == w.value) begin
            r.status         = ST_OK;
            r.found_position = LEN_W'(k + 1);
          end
        end
      end
      default: begin
        if (pos < 1 || pos > len) r.status = ST_BAD_POS;
        else nxt.slot[pos-1] = w.value;
      end
    endcase
    r.count = nxt.len;
    return r;
  endfunction

  task automatic log_failure(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    fail_count++;
  endtask

  // Driver: predicts each accepted word, then offers the next one unless idling.
  always @(posedge clk) begin
    if (in_valid && !in_stall) begin
      results_due.push_back(apply_list_op(list_model, in_data, list_after));
      list_model = list_after;
    end
    if (!in_valid || !in_stall) begin
      if (words_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data  <= words_to_send.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: stalls at random or during the long hold, and checks every accepted result.
  always @(posedge clk) begin
    out_stall <= (hold_left > 0) || ($urandom_range(99) < recv_idle_pct);
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (results_due.size() == 0) begin
        log_failure($sformatf("result %0d arrived with nothing expected", result_index));
      end else begin
        oldest_result = results_due.pop_front();
        if (out_data.status !== oldest_result.status)
          log_failure($sformatf("result %0d status %0d, expected %0d", result_index,
                                out_data.status, oldest_result.status));
        if (out_data.value_out !== oldest_result.value_out)
          log_failure($sformatf("result %0d value_out %0d, expected %0d", result_index,
                                out_data.value_out, oldest_result.value_out));
        if (out_data.found_position !== oldest_result.found_position)
          log_failure($sformatf("result %0d found_position %0d, expected %0d", result_index,
                                out_data.found_position, oldest_result.found_position));
        if (out_data.count !== oldest_result.count)
          log_failure($sformatf("result %0d count %0d, expected %0d", result_index,
                                out_data.count, oldest_result.count));
      end
      result_index++;
    end
  end

  // Long receiver hold, granted once on request, counted here.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_request && !hold_spent) begin
      hold_left  <= HOLD_CYCLES;
      hold_spent <= 1'b1;
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic queue_word(input logic [1:0] fn, input int pos,
                            input logic [DATA_WIDTH-1:0] val);
    in_word_t w;
    w.func     = fn;
    w.position = POS_W'(pos);
    w.value    = val;
    words_to_send.push_back(w);
  endtask

  // Mostly well-formed operations on the planned list, with some wild positions.
  task automatic queue_random_words(input int n);
    in_word_t    w;
    list_image_t after;
    int roll;
    int len_now;
    for (int i = 0; i < n; i++) begin
      len_now = int'(plan_image.len);
      roll    = $urandom_range(99);
      if (roll < 35) w.func = FN_INSERT;
      else if (roll < 65) w.func = FN_REMOVE;
      else if (roll < 85) w.func = FN_FIND;
      else w.func = FN_SET;
      if ($urandom_range(99) < 15) w.position = POS_W'($urandom_range(255));
      else if (w.func == FN_INSERT) w.position = POS_W'($urandom_range(len_now + 1, 1));
      else if (len_now == 0) w.position = POS_W'(1);
      else w.position = POS_W'($urandom_range(len_now, 1));
      if (w.func == FN_FIND && len_now != 0 && $urandom_range(99) < 70)
        w.value = plan_image.slot[$urandom_range(len_now - 1)];
      else if ($urandom_range(99) < 30)
        w.value = value_pool[$urandom_range(7)];
      else
        w.value = $urandom;
      words_to_send.push_back(w);
      void'(apply_list_op(plan_image, w, after));
      plan_image = after;
    end
  endtask

  // Returns once every word has gone in and every result has come out.
  task automatic wait_idle();
    @(negedge clk);
    while (words_to_send.size() != 0 || in_valid) @(negedge clk);
    while (results_due.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    @(posedge clk);
    cfg_data  <= cap;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    list_model.cap = cap;
  endtask

  task automatic set_idle(input int send_pct, input int recv_pct);
    @(negedge clk);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  task automatic run_random_phase(input logic [CAP_W-1:0] cap, input int send_pct,
                                  input int recv_pct);
    wait_idle();
    write_capacity(cap);
    set_idle(send_pct, recv_pct);
    plan_image = list_model;
    queue_random_words(RANDOM_ITEMS);
  endtask

  initial begin : stimulus
    list_model     = '0;
    list_model.cap = CAP_RESET;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    set_idle(11, 72);

    // Empty list: every positional operation is out of range, find misses.
    queue_word(FN_REMOVE, 1, 32'd0);
    queue_word(FN_SET, 1, 32'd9);
    queue_word(FN_FIND, 0, 32'd0);
    queue_word(FN_INSERT, 0, 32'd5);
    queue_word(FN_INSERT, 2, 32'd5);
    // Inserts at the head, the tail and the middle, with the value extremes.
    queue_word(FN_INSERT, 1, VAL_MAX);
    queue_word(FN_INSERT, 1, VAL_MIN);
    queue_word(FN_INSERT, 3, VAL_NEG);
    queue_word(FN_INSERT, 255, 32'd3);
    queue_word(FN_INSERT, 2, VAL_NEG);
    // Find returns the first of two equal entries and ignores its position.
    queue_word(FN_FIND, 255, VAL_NEG);
    queue_word(FN_SET, 4, 32'd0);
    queue_word(FN_SET, 5, 32'd1);
    queue_word(FN_SET, 255, 32'd1);
    queue_word(FN_REMOVE, 0, 32'd0);
    queue_word(FN_REMOVE, 5, 32'd0);
    queue_word(FN_REMOVE, 4, 32'd0);
    queue_word(FN_FIND, 7, 32'd0);
    wait_idle();

    // Capacity below the current length: inserts report full, even with a bad position.
    write_capacity(5'd2);
    queue_word(FN_INSERT, 1, 32'd11);
    queue_word(FN_INSERT, 0, 32'd11);
    queue_word(FN_REMOVE, 1, 32'd0);
    queue_word(FN_INSERT, 1, 32'd11);
    wait_idle();

    // Zero capacity refuses every insert.
    write_capacity(5'd0);
    queue_word(FN_INSERT, 1, 32'd12);
    wait_idle();

    // Capacity above the depth saturates.
    write_capacity(5'd31);
    queue_word(FN_INSERT, 3, 32'd7);
    queue_word(FN_REMOVE, 2, 32'd0);

    run_random_phase(5'd16, 11, 72);
    run_random_phase(5'd5, 72, 11);
    run_random_phase(5'd9, 0, 0);

    // Once the stream is running, hold the receiver off so the block backs up.
    while (words_to_send.size() > RANDOM_ITEMS - 20) @(negedge clk);
    hold_request = 1'b1;

    wait_idle();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/ple_pkg.sv
sv/ple_cell.sv
sv/positional_list_engine_unit.sv
tb/sv/tb_positional_list_engine_unit.sv
